// File: hw/rtl/life_grid_with_pen_drawing_assert.svh
// Assertion macros for the life grid block.
// Every macro samples on clk and is switched off while rst is high.
`ifndef LIFE_GRID_WITH_PEN_DRAWING_ASSERT_SVH
`define LIFE_GRID_WITH_PEN_DRAWING_ASSERT_SVH

// Same-cycle implication.
`define LGPD_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define LGPD_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: hw/rtl/lgpd_pkg.sv
// Shared types, constants and functions for the life grid block.
// No dependencies; used by the controller, the datapath and the top level.
`timescale 1ns / 1ps

package lgpd_pkg;

  localparam int MAX_COLS = 64;
  localparam int MAX_ROWS = 64;
  localparam int ROW_W    = $clog2(MAX_ROWS);
  localparam int COL_W    = $clog2(MAX_COLS);
  localparam int DIM_W    = 7;
  localparam int GEN_W    = 16;
  localparam int KEY_W    = 8;
  localparam int CMD_W    = 2;

  typedef logic [MAX_COLS-1:0] row_t;

  // Command codes
  localparam logic [CMD_W-1:0] CMD_KEY   = 2'd0;
  localparam logic [CMD_W-1:0] CMD_GEN   = 2'd1;
  localparam logic [CMD_W-1:0] CMD_READ  = 2'd2;
  localparam logic [CMD_W-1:0] CMD_CLEAR = 2'd3;

  // Key bytes (ASCII)
  localparam logic [KEY_W-1:0] KEY_UP    = 8'h77;
  localparam logic [KEY_W-1:0] KEY_DOWN  = 8'h73;
  localparam logic [KEY_W-1:0] KEY_LEFT  = 8'h61;
  localparam logic [KEY_W-1:0] KEY_RIGHT = 8'h64;
  localparam logic [KEY_W-1:0] KEY_PEN   = 8'h78;

  // Configuration register indexes
  localparam logic REG_WIDTH  = 1'b0;
  localparam logic REG_HEIGHT = 1'b1;

  localparam logic [DIM_W-1:0] DIM_RESET = 7'd64;

  // Controller to datapath commands
  typedef struct packed {
    logic capture;
    logic pen_step;
    logic draw_rd;
    logic draw_wr;
    logic row_rd;
    logic row_cap;
    logic gen_prime0;
    logic gen_prime1;
    logic gen_sweep;
    logic gen_end;
    logic clear;
    logic out_load;
  } dp_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic draw;
    logic gens_zero;
    logic gens_one;
    logic last_row;
    logic changed;
  } dp_status_t;

  // Clamp a configured dimension to 1..lim
  function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] d,
                                                 input logic [DIM_W-1:0] lim);
    logic [DIM_W-1:0] r;
    r = d;
    if (d == '0) r = DIM_W'(1);
    else if (d > lim) r = lim;
    return r;
  endfunction

  // One B3/S23 row update; inputs already masked to the columns in use
  function automatic row_t life_row(input row_t up, input row_t cur,
                                    input row_t down, input row_t m);
    row_t a, b, c, d, e, f, g, h, nxt;
    a = (up << 1) & m;
    b = up;
    c = up >> 1;
    d = (cur << 1) & m;
    e = cur >> 1;
    f = (down << 1) & m;
    g = down;
    h = down >> 1;
    for (int k = 0; k < MAX_COLS; k++) begin
      logic [3:0] n;
      n = 4'(a[k]) + 4'(b[k]) + 4'(c[k]) + 4'(d[k]) +
          4'(e[k]) + 4'(f[k]) + 4'(g[k]) + 4'(h[k]);
      nxt[k] = (n == 4'd3) || ((n == 4'd2) && cur[k]);
    end
    return nxt & m;
  endfunction

endpackage

// File: hw/rtl/lgpd_ram.sv
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
`timescale 1ns / 1ps

module lgpd_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// File: hw/rtl/lgpd_ctrl.sv
// Controller state machine for the life grid block.
// Depends on lgpd_pkg and life_grid_with_pen_drawing_assert.svh.
`timescale 1ns / 1ps
`include "life_grid_with_pen_drawing_assert.svh"

module lgpd_ctrl (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       cmd_valid,
  output logic                       cmd_stall,
  input  logic [lgpd_pkg::CMD_W-1:0] cmd,
  output logic                       res_valid,
  input  logic                       res_stall,
  output lgpd_pkg::dp_cmd_t          ctl,
  input  lgpd_pkg::dp_status_t       st
);

  localparam logic [3:0] S_IDLE    = 4'd0;
  localparam logic [3:0] S_KEY     = 4'd1;
  localparam logic [3:0] S_DRAW_RD = 4'd2;
  localparam logic [3:0] S_DRAW_WR = 4'd3;
  localparam logic [3:0] S_ROW_RD  = 4'd4;
  localparam logic [3:0] S_ROW_CAP = 4'd5;
  localparam logic [3:0] S_GEN_CHK = 4'd6;
  localparam logic [3:0] S_PRIME0  = 4'd7;
  localparam logic [3:0] S_PRIME1  = 4'd8;
  localparam logic [3:0] S_SWEEP   = 4'd9;
  localparam logic [3:0] S_GEN_END = 4'd10;
  localparam logic [3:0] S_CLEAR   = 4'd11;
  localparam logic [3:0] S_DONE    = 4'd12;

  logic [3:0] state;
  logic [3:0] state_next;
  logic       res_valid_next;
  logic       accept;
  logic       out_free;

  assign cmd_stall = (state != S_IDLE);
  assign accept    = cmd_valid && !cmd_stall;
  assign out_free  = !res_valid || !res_stall;

  // Next state and datapath commands
  always_comb begin
    state_next = state;
    ctl        = '0;
    case (state)
      S_IDLE: begin
        ctl.capture = accept;
        if (accept) begin
          case (cmd)
            lgpd_pkg::CMD_KEY:  state_next = S_KEY;
            lgpd_pkg::CMD_GEN:  state_next = S_GEN_CHK;
            lgpd_pkg::CMD_READ: state_next = S_ROW_RD;
            default:            state_next = S_CLEAR;
          endcase
        end
      end
      S_KEY: begin
        ctl.pen_step = 1'b1;
        state_next   = st.draw ? S_DRAW_RD : S_DONE;
      end
      S_DRAW_RD: begin
        ctl.draw_rd = 1'b1;
        state_next  = S_DRAW_WR;
      end
      S_DRAW_WR: begin
        ctl.draw_wr = 1'b1;
        state_next  = S_DONE;
      end
      S_ROW_RD: begin
        ctl.row_rd = 1'b1;
        state_next = S_ROW_CAP;
      end
      S_ROW_CAP: begin
        ctl.row_cap = 1'b1;
        state_next  = S_DONE;
      end
      S_GEN_CHK: begin
        state_next = st.gens_zero ? S_DONE : S_PRIME0;
      end
      S_PRIME0: begin
        ctl.gen_prime0 = 1'b1;
        state_next     = S_PRIME1;
      end
      S_PRIME1: begin
        ctl.gen_prime1 = 1'b1;
        state_next     = S_SWEEP;
      end
      S_SWEEP: begin
        ctl.gen_sweep = 1'b1;
        if (st.last_row) state_next = S_GEN_END;
      end
      S_GEN_END: begin
        // stop on the last generation or once the grid has settled
        ctl.gen_end = 1'b1;
        state_next  = (st.gens_one || !st.changed) ? S_DONE : S_PRIME0;
      end
      S_CLEAR: begin
        ctl.clear  = 1'b1;
        state_next = S_DONE;
      end
      S_DONE: begin
        ctl.out_load = out_free;
        if (out_free) state_next = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // Output valid: set on load, drop when the transaction completes
  always_comb begin
    res_valid_next = res_valid;
    if (ctl.out_load) res_valid_next = 1'b1;
    else if (!res_stall) res_valid_next = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      res_valid <= 1'b0;
    end else begin
      state     <= state_next;
      res_valid <= res_valid_next;
    end
  end

  `LGPD_ASSERT_NEXT(a_done_posts, (state == S_DONE) && !res_valid, res_valid && (state == S_IDLE), "finished result was not posted")
  `LGPD_ASSERT_SAME(a_sweep_has_gens, state == S_SWEEP, !st.gens_zero, "sweeping with no generations left")

endmodule

// File: hw/rtl/lgpd_dp.sv
// Datapath for the life grid block: config registers, pen, row memory,
// generation sweep window and result register.
// Depends on lgpd_pkg, lgpd_ram and life_grid_with_pen_drawing_assert.svh.
`timescale 1ns / 1ps
`include "life_grid_with_pen_drawing_assert.svh"

module lgpd_dp (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       cfg_valid,
  output logic                       cfg_ready,
  input  logic                       cfg_index,
  input  logic [lgpd_pkg::DIM_W-1:0] cfg_data,
  input  logic [lgpd_pkg::KEY_W-1:0] key_byte,
  input  logic [lgpd_pkg::GEN_W-1:0] gen_count,
  input  logic [lgpd_pkg::ROW_W-1:0] row_select,
  output lgpd_pkg::row_t             row_bits,
  output logic [lgpd_pkg::ROW_W-1:0] pen_row_out,
  output logic [lgpd_pkg::COL_W-1:0] pen_col_out,
  output logic                       pen_is_down,
  input  lgpd_pkg::dp_cmd_t          ctl,
  output lgpd_pkg::dp_status_t       st
);

  localparam int DIM_W = lgpd_pkg::DIM_W;
  localparam int ROW_W = lgpd_pkg::ROW_W;

  // Configuration and derived geometry
  logic [DIM_W-1:0]   grid_width;
  logic [DIM_W-1:0]   grid_height;
  logic [DIM_W-1:0]   rows_eff;
  logic [DIM_W-1:0]   cols_eff;
  lgpd_pkg::row_t     col_mask;

  // Captured command fields
  logic [lgpd_pkg::KEY_W-1:0] key_q;
  logic [lgpd_pkg::GEN_W-1:0] gens_left;
  logic [ROW_W-1:0]           row_sel_q;

  // Pen
  logic [ROW_W-1:0]           pen_row;
  logic [lgpd_pkg::COL_W-1:0] pen_col;
  logic                       pen_down;

  // Memory side
  logic [lgpd_pkg::MAX_ROWS-1:0] row_valid;
  logic                          rd_en;
  logic [ROW_W-1:0]              rd_addr;
  lgpd_pkg::row_t                rd_data;
  logic                          rd_valid_q;
  lgpd_pkg::row_t                rd_row;
  logic                          wr_en;
  logic [ROW_W-1:0]              wr_addr;
  lgpd_pkg::row_t                wr_data;

  // Sweep window
  lgpd_pkg::row_t   up_row;
  lgpd_pkg::row_t   cur_row;
  logic [ROW_W-1:0] sweep_row;
  logic [DIM_W-1:0] sweep_row_ext;
  logic             changed;
  lgpd_pkg::row_t   down_in;
  lgpd_pkg::row_t   cur_masked;
  lgpd_pkg::row_t   new_row;

  lgpd_pkg::row_t   result_row;
  logic             key_known;

  assign cfg_ready = 1'b1;

  // Configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      grid_width  <= lgpd_pkg::DIM_RESET;
      grid_height <= lgpd_pkg::DIM_RESET;
    end else if (cfg_valid && cfg_ready) begin
      if (cfg_index == lgpd_pkg::REG_WIDTH) grid_width <= cfg_data;
      else grid_height <= cfg_data;
    end
  end

  // Hold clamped geometry in registers
  always_ff @(posedge clk) begin
    if (rst) begin
      rows_eff <= DIM_W'(lgpd_pkg::MAX_ROWS);
      cols_eff <= DIM_W'(lgpd_pkg::MAX_COLS);
      col_mask <= '1;
    end else begin
      rows_eff <= lgpd_pkg::clamp_dim(grid_height, DIM_W'(lgpd_pkg::MAX_ROWS));
      cols_eff <= lgpd_pkg::clamp_dim(grid_width, DIM_W'(lgpd_pkg::MAX_COLS));
      col_mask <= lgpd_pkg::row_t'('1) >>
                  (DIM_W'(lgpd_pkg::MAX_COLS) -
                   lgpd_pkg::clamp_dim(grid_width, DIM_W'(lgpd_pkg::MAX_COLS)));
    end
  end

  // Key decode: recognized keys draw when the pen ends up down
  always_comb begin
    case (key_q)
      lgpd_pkg::KEY_UP, lgpd_pkg::KEY_DOWN, lgpd_pkg::KEY_LEFT,
      lgpd_pkg::KEY_RIGHT, lgpd_pkg::KEY_PEN: key_known = 1'b1;
      default:                                key_known = 1'b0;
    endcase
  end

  // Memory read address and gated read data
  assign rd_en = ctl.draw_rd || ctl.row_rd || ctl.gen_prime0 ||
                 ctl.gen_prime1 || ctl.gen_sweep;
  always_comb begin
    rd_addr = sweep_row + ROW_W'(2);
    if (ctl.draw_rd) rd_addr = pen_row;
    else if (ctl.row_rd) rd_addr = row_sel_q;
    else if (ctl.gen_prime0) rd_addr = '0;
    else if (ctl.gen_prime1) rd_addr = ROW_W'(1);
  end
  assign rd_row = rd_valid_q ? rd_data : '0;

  // Sweep row computation
  assign sweep_row_ext = DIM_W'(sweep_row);
  assign down_in    = ((sweep_row_ext + DIM_W'(1)) < rows_eff) ? rd_row : '0;
  assign cur_masked = cur_row & col_mask;
  assign new_row    = lgpd_pkg::life_row(up_row, cur_masked, down_in & col_mask, col_mask);

  // Memory write: pen draw or generation row, hidden columns kept
  assign wr_en   = ctl.draw_wr || ctl.gen_sweep;
  assign wr_addr = ctl.draw_wr ? pen_row : sweep_row;
  assign wr_data = ctl.draw_wr ? (rd_row | (lgpd_pkg::row_t'(1) << pen_col))
                               : ((cur_row & ~col_mask) | new_row);

  lgpd_ram #(
    .WIDTH(lgpd_pkg::MAX_COLS),
    .DEPTH(lgpd_pkg::MAX_ROWS)
  ) u_grid (
    .clk    (clk),
    .wr_en  (wr_en),
    .wr_addr(wr_addr),
    .wr_data(wr_data),
    .rd_en  (rd_en),
    .rd_addr(rd_addr),
    .rd_data(rd_data)
  );

  // Row valid bits: an unwritten row reads as dead
  always_ff @(posedge clk) begin
    if (rst || ctl.clear) begin
      row_valid  <= '0;
      rd_valid_q <= 1'b0;
    end else begin
      if (wr_en) row_valid[wr_addr] <= 1'b1;
      if (rd_en) rd_valid_q <= row_valid[rd_addr];
    end
  end

  // Pen state
  always_ff @(posedge clk) begin
    if (rst || ctl.clear) begin
      pen_row  <= '0;
      pen_col  <= '0;
      pen_down <= 1'b0;
    end else if (ctl.pen_step) begin
      case (key_q)
        lgpd_pkg::KEY_UP: begin
          if (pen_row != '0) pen_row <= pen_row - ROW_W'(1);
        end
        lgpd_pkg::KEY_DOWN: begin
          if ((DIM_W'(pen_row) + DIM_W'(1)) < rows_eff) pen_row <= pen_row + ROW_W'(1);
        end
        lgpd_pkg::KEY_LEFT: begin
          if (pen_col != '0) pen_col <= pen_col - lgpd_pkg::COL_W'(1);
        end
        lgpd_pkg::KEY_RIGHT: begin
          if ((DIM_W'(pen_col) + DIM_W'(1)) < cols_eff) pen_col <= pen_col + lgpd_pkg::COL_W'(1);
        end
        lgpd_pkg::KEY_PEN: begin
          pen_down <= !pen_down;
        end
        default: begin
          pen_down <= pen_down;
        end
      endcase
    end
  end

  // Command capture, generation counter and sweep window
  always_ff @(posedge clk) begin
    if (rst || ctl.clear) begin
      gens_left <= '0;
      sweep_row <= '0;
      up_row    <= '0;
      changed   <= 1'b0;
    end else begin
      if (ctl.capture) gens_left <= gen_count;
      if (ctl.gen_prime0) begin
        sweep_row <= '0;
        changed   <= 1'b0;
      end
      if (ctl.gen_prime1) up_row <= '0;
      if (ctl.gen_sweep) begin
        up_row    <= cur_masked;
        sweep_row <= sweep_row + ROW_W'(1);
        changed   <= changed || (new_row != cur_masked);
      end
      if (ctl.gen_end) begin
        sweep_row <= '0;
        gens_left <= changed ? (gens_left - lgpd_pkg::GEN_W'(1)) : '0;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (ctl.capture) begin
      key_q      <= key_byte;
      row_sel_q  <= row_select;
      result_row <= '0;
    end
    if (ctl.row_cap) begin
      result_row <= (DIM_W'(row_sel_q) < rows_eff) ? (rd_row & col_mask) : '0;
    end
    if (ctl.gen_prime1) cur_row <= rd_row;
    if (ctl.gen_sweep) cur_row <= down_in;
    if (ctl.out_load) begin
      row_bits    <= result_row;
      pen_row_out <= pen_row;
      pen_col_out <= pen_col;
      pen_is_down <= pen_down;
    end
  end

  // Status
  assign st.draw      = key_known && (pen_down ^ (key_q == lgpd_pkg::KEY_PEN));
  assign st.gens_zero = (gens_left == '0);
  assign st.gens_one  = (gens_left == lgpd_pkg::GEN_W'(1));
  assign st.last_row  = ((sweep_row_ext + DIM_W'(1)) == rows_eff);
  assign st.changed   = changed;

  `LGPD_ASSERT_NEXT(a_clear_empties, ctl.clear, row_valid == '0, "grid not empty after clear")
  `LGPD_ASSERT_SAME(a_sweep_in_area, ctl.gen_sweep, sweep_row_ext < rows_eff, "sweep row outside grid")

endmodule

// File: hw/rtl/life_grid_with_pen_drawing.sv
// Top level of the life grid block: controller plus datapath.
// Depends on lgpd_pkg, lgpd_ctrl, lgpd_dp (which holds lgpd_ram).
`timescale 1ns / 1ps

// Bounded Conway B3/S23 grid (64x64 storage) with a drawing pen. Each command
// transaction yields one result transaction carrying the row read (zero for
// non-read commands) and the pen position and state after the command. When
// the pen draws, a key command adds a read-modify-write of the pen's row. The
// grid lives in a single-read-port row memory and every generation sweeps it
// one row per cycle, after priming the row window, and closes with an end step.
// The run ends early once a generation leaves the grid unchanged. A new
// command is taken while the previous result still waits to be taken. Grid
// width and height are written on the config channel (always ready); the user
// must write them only while the block is idle, which the block itself does
// not enforce. The grid needs no clearing pass after reset.
module life_grid_with_pen_drawing (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       cfg_valid,
  output logic                       cfg_ready,
  input  logic                       cfg_index,
  input  logic [lgpd_pkg::DIM_W-1:0] cfg_data,
  input  logic                       cmd_valid,
  output logic                       cmd_stall,
  input  logic [lgpd_pkg::CMD_W-1:0] cmd,
  input  logic [lgpd_pkg::KEY_W-1:0] key_byte,
  input  logic [lgpd_pkg::GEN_W-1:0] gen_count,
  input  logic [lgpd_pkg::ROW_W-1:0] row_select,
  output logic                       res_valid,
  input  logic                       res_stall,
  output lgpd_pkg::row_t             row_bits,
  output logic [lgpd_pkg::ROW_W-1:0] pen_row_out,
  output logic [lgpd_pkg::COL_W-1:0] pen_col_out,
  output logic                       pen_is_down
);

  lgpd_pkg::dp_cmd_t    ctl;
  lgpd_pkg::dp_status_t st;

  lgpd_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .cmd_valid(cmd_valid),
    .cmd_stall(cmd_stall),
    .cmd      (cmd),
    .res_valid(res_valid),
    .res_stall(res_stall),
    .ctl      (ctl),
    .st       (st)
  );

  lgpd_dp u_dp (
    .clk        (clk),
    .rst        (rst),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .key_byte   (key_byte),
    .gen_count  (gen_count),
    .row_select (row_select),
    .row_bits   (row_bits),
    .pen_row_out(pen_row_out),
    .pen_col_out(pen_col_out),
    .pen_is_down(pen_is_down),
    .ctl        (ctl),
    .st         (st)
  );

endmodule

// File: sim/tb_life_grid_with_pen_drawing.sv
`timescale 1ns / 1ps
// Self-checking testbench for life_grid_with_pen_drawing: pen moves, drawing, B3/S23 runs,
// row reads, clears and grid size changes, checked against a built-in predictor.
// Depends on lgpd_pkg and the life_grid_with_pen_drawing RTL.

module tb_life_grid_with_pen_drawing;

  typedef struct packed {
    lgpd_pkg::row_t             bits;
    logic [lgpd_pkg::ROW_W-1:0] prow;
    logic [lgpd_pkg::COL_W-1:0] pcol;
    logic                       down;
  } pen_report_t;

  logic                       clk = 1'b0;
  logic                       rst = 1'b1;
  logic                       cfg_valid = 1'b0;
  logic                       cfg_ready;
  logic                       cfg_index = lgpd_pkg::REG_WIDTH;
  logic [lgpd_pkg::DIM_W-1:0] cfg_data = '0;
  logic                       cmd_valid = 1'b0;
  logic                       cmd_stall;
  logic [lgpd_pkg::CMD_W-1:0] cmd = lgpd_pkg::CMD_KEY;
  logic [lgpd_pkg::KEY_W-1:0] key_byte = '0;
  logic [lgpd_pkg::GEN_W-1:0] gen_count = '0;
  logic [lgpd_pkg::ROW_W-1:0] row_select = '0;
  logic                       res_valid;
  logic                       res_stall = 1'b0;
  lgpd_pkg::row_t             row_bits;
  logic [lgpd_pkg::ROW_W-1:0] pen_row_out;
  logic [lgpd_pkg::COL_W-1:0] pen_col_out;
  logic                       pen_is_down;

  // Predicted block state
  lgpd_pkg::row_t             life_cells [lgpd_pkg::MAX_ROWS];
  lgpd_pkg::row_t             snap_cur [lgpd_pkg::MAX_ROWS];
  lgpd_pkg::row_t             snap_old [lgpd_pkg::MAX_ROWS];
  logic [lgpd_pkg::ROW_W-1:0] pen_r;
  logic [lgpd_pkg::COL_W-1:0] pen_c;
  logic                       pen_dn;
  logic [lgpd_pkg::DIM_W-1:0] width_reg;
  logic [lgpd_pkg::DIM_W-1:0] height_reg;

  pen_report_t pending_reports [$];

  int gap_pct = 0;
  int stall_pct = 0;
  int stall_left = 0;
  int error_count = 0;
  int reports_checked = 0;
  int dim_settings = 0;
  int cmd_tally [4] = '{0, 0, 0, 0};

  always #2 clk = ~clk;

  life_grid_with_pen_drawing dut (
    .clk         (clk),
    .rst         (rst),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .cmd_valid   (cmd_valid),
    .cmd_stall   (cmd_stall),
    .cmd         (cmd),
    .key_byte    (key_byte),
    .gen_count   (gen_count),
    .row_select  (row_select),
    .res_valid   (res_valid),
    .res_stall   (res_stall),
    .row_bits    (row_bits),
    .pen_row_out (pen_row_out),
    .pen_col_out (pen_col_out),
    .pen_is_down (pen_is_down)
  );

  // ---------------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------------

  function automatic int rows_in_use();
    int h;
    h = height_reg;
    if (h < 1) h = 1;
    if (h > lgpd_pkg::MAX_ROWS) h = lgpd_pkg::MAX_ROWS;
    return h;
  endfunction

  function automatic int cols_in_use();
    int w;
    w = width_reg;
    if (w < 1) w = 1;
    if (w > lgpd_pkg::MAX_COLS) w = lgpd_pkg::MAX_COLS;
    return w;
  endfunction

  function automatic lgpd_pkg::row_t live_mask();
    lgpd_pkg::row_t all_ones;
    all_ones = '1;
    return all_ones >> (lgpd_pkg::MAX_COLS - cols_in_use());
  endfunction

  function automatic void clear_cells();
    for (int r = 0; r < lgpd_pkg::MAX_ROWS; r++) life_cells[r] = '0;
    pen_r = '0;
    pen_c = '0;
    pen_dn = 1'b0;
  endfunction

  // True when no live cell sits inside the area in use
  function automatic bit area_is_dead();
    lgpd_pkg::row_t m;
    m = live_mask();
    for (int r = 0; r < rows_in_use(); r++)
      if ((life_cells[r] & m) != '0) return 1'b0;
    return 1'b1;
  endfunction

  // Compare the grid with the snapshot taken before (or two before) this generation
  function automatic bit grid_equals(input bit vs_old);
    for (int r = 0; r < lgpd_pkg::MAX_ROWS; r++)
      if (life_cells[r] != (vs_old ? snap_old[r] : snap_cur[r])) return 1'b0;
    return 1'b1;
  endfunction

  // Count the eight neighbours of each column and apply birth on 3, survival on 2 or 3
  function automatic lgpd_pkg::row_t evolve_row(input lgpd_pkg::row_t above,
                                                input lgpd_pkg::row_t here,
                                                input lgpd_pkg::row_t below,
                                                input lgpd_pkg::row_t m);
    lgpd_pkg::row_t nxt;
    int             n;
    nxt = '0;
    for (int k = 0; k < lgpd_pkg::MAX_COLS; k++) begin
      n = 0;
      for (int j = k - 1; j <= k + 1; j++) begin
        if (j >= 0 && j < lgpd_pkg::MAX_COLS) begin
          n += int'(above[j]) + int'(below[j]);
          if (j != k) n += int'(here[j]);
        end
      end
      nxt[k] = m[k] && (n == 3 || (n == 2 && here[k]));
    end
    return nxt;
  endfunction

  // Sweep the rows in use once; hidden columns and rows keep their contents
  function automatic void life_generation();
    lgpd_pkg::row_t m, above, here, below;
    int             h;
    h = rows_in_use();
    m = live_mask();
    above = '0;
    for (int r = 0; r < h; r++) begin
      here = life_cells[r] & m;
      below = (r + 1 < h) ? (life_cells[r + 1] & m) : '0;
      life_cells[r] = (life_cells[r] & ~m) | evolve_row(above, here, below, m);
      above = here;
    end
  endfunction

  // Run generations, stopping early on a still life or a period-two oscillator
  function automatic void run_life(input int unsigned count);
    int unsigned left;
    bit          have_old;
    left = count;
    have_old = 1'b0;
    while (left > 0) begin
      for (int r = 0; r < lgpd_pkg::MAX_ROWS; r++) snap_cur[r] = life_cells[r];
      life_generation();
      left--;
      if (grid_equals(1'b0)) break;
      if (have_old && grid_equals(1'b1)) begin
        // land on the phase an odd remainder would reach
        if (left[0])
          for (int r = 0; r < lgpd_pkg::MAX_ROWS; r++) life_cells[r] = snap_cur[r];
        break;
      end
      for (int r = 0; r < lgpd_pkg::MAX_ROWS; r++) snap_old[r] = snap_cur[r];
      have_old = 1'b1;
    end
  endfunction

  function automatic void apply_key(input logic [lgpd_pkg::KEY_W-1:0] k);
    case (k)
      lgpd_pkg::KEY_UP:    if (pen_r > 0) pen_r--;
      lgpd_pkg::KEY_DOWN:  if (int'(pen_r) + 1 < rows_in_use()) pen_r++;
      lgpd_pkg::KEY_LEFT:  if (pen_c > 0) pen_c--;
      lgpd_pkg::KEY_RIGHT: if (int'(pen_c) + 1 < cols_in_use()) pen_c++;
      lgpd_pkg::KEY_PEN:   pen_dn = ~pen_dn;
      default:             return;
    endcase
    // a lowered pen marks the cell under it, even outside the area in use
    if (pen_dn) life_cells[pen_r][pen_c] = 1'b1;
  endfunction

  // Advance the predicted state by one command and return the report it yields
  function automatic pen_report_t model_command(input logic [lgpd_pkg::CMD_W-1:0] c,
                                                input logic [lgpd_pkg::KEY_W-1:0] k,
                                                input logic [lgpd_pkg::GEN_W-1:0] g,
                                                input logic [lgpd_pkg::ROW_W-1:0] rs);
    pen_report_t rep;
    rep.bits = '0;
    case (c)
      lgpd_pkg::CMD_KEY:   apply_key(k);
      lgpd_pkg::CMD_GEN:   run_life(g);
      lgpd_pkg::CMD_READ:  if (int'(rs) < rows_in_use()) rep.bits = life_cells[rs] & live_mask();
      lgpd_pkg::CMD_CLEAR: clear_cells();
      default:             ;
    endcase
    rep.prow = pen_r;
    rep.pcol = pen_c;
    rep.down = pen_dn;
    return rep;
  endfunction

  // ---------------------------------------------------------------------------
  // Result side: random stall bursts and the checker
  // ---------------------------------------------------------------------------

  always @(posedge clk) begin
    if (rst || stall_pct == 0) begin
      res_stall <= 1'b0;
      stall_left <= 0;
    end else if (stall_left > 0) begin
      res_stall <= 1'b1;
      stall_left <= stall_left - 1;
    end else if ($urandom_range(0, 99) < stall_pct) begin
      res_stall <= 1'b1;
      stall_left <= $urandom_range(0, 10);
    end else begin
      res_stall <= 1'b0;
    end
  end

  always @(posedge clk) begin : check_results
    pen_report_t want;
    if (!rst && res_valid && !res_stall) begin
      if (pending_reports.size() == 0) begin
        $error("result transaction with nothing expected");
        error_count++;
      end else begin
        want = pending_reports.pop_front();
        reports_checked++;
        if (row_bits !== want.bits) begin
          $error("row_bits: expected %h, got %h", want.bits, row_bits);
          error_count++;
        end
        if (pen_row_out !== want.prow) begin
          $error("pen_row_out: expected %0d, got %0d", want.prow, pen_row_out);
          error_count++;
        end
        if (pen_col_out !== want.pcol) begin
          $error("pen_col_out: expected %0d, got %0d", want.pcol, pen_col_out);
          error_count++;
        end
        if (pen_is_down !== want.down) begin
          $error("pen_is_down: expected %0d, got %0d", want.down, pen_is_down);
          error_count++;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------

  // Send one command transaction; valid stays high so a following one can go back to back
  task automatic issue_command(input logic [lgpd_pkg::CMD_W-1:0] c,
                               input logic [lgpd_pkg::KEY_W-1:0] k,
                               input logic [lgpd_pkg::GEN_W-1:0] g,
                               input logic [lgpd_pkg::ROW_W-1:0] rs);
    if (gap_pct > 0 && $urandom_range(0, 99) < gap_pct) begin
      cmd_valid <= 1'b0;
      repeat ($urandom_range(1, 11)) @(posedge clk);
    end
    cmd_valid <= 1'b1;
    cmd <= c;
    key_byte <= k;
    gen_count <= g;
    row_select <= rs;
    @(posedge clk);
    while (!(cmd_valid && !cmd_stall)) @(posedge clk);
    pending_reports.push_back(model_command(c, k, g, rs));
    cmd_tally[c]++;
  endtask

  // Drop valid and let every outstanding result drain
  task automatic wait_idle();
    cmd_valid <= 1'b0;
    @(posedge clk);
    while (pending_reports.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // Write both size registers; call only while idle
  task automatic set_dims(input logic [lgpd_pkg::DIM_W-1:0] w,
                          input logic [lgpd_pkg::DIM_W-1:0] h);
    cfg_valid <= 1'b1;
    cfg_index <= lgpd_pkg::REG_WIDTH;
    cfg_data <= w;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    width_reg = w;
    cfg_index <= lgpd_pkg::REG_HEIGHT;
    cfg_data <= h;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    height_reg = h;
    cfg_valid <= 1'b0;
    dim_settings++;
  endtask

  task automatic key(input logic [lgpd_pkg::KEY_W-1:0] k);
    issue_command(lgpd_pkg::CMD_KEY, k, lgpd_pkg::GEN_W'($urandom),
                  lgpd_pkg::ROW_W'($urandom));
  endtask

  task automatic read_row(input logic [lgpd_pkg::ROW_W-1:0] rs);
    issue_command(lgpd_pkg::CMD_READ, lgpd_pkg::KEY_W'($urandom),
                  lgpd_pkg::GEN_W'($urandom), rs);
  endtask

  task automatic run_gens(input logic [lgpd_pkg::GEN_W-1:0] g);
    issue_command(lgpd_pkg::CMD_GEN, lgpd_pkg::KEY_W'($urandom), g,
                  lgpd_pkg::ROW_W'($urandom));
  endtask

  // One random command, mostly pen strokes, steps and reads with random content
  task automatic random_command();
    int                         pick;
    logic [lgpd_pkg::KEY_W-1:0] k;
    logic [lgpd_pkg::GEN_W-1:0] g;
    logic [lgpd_pkg::ROW_W-1:0] rs;
    pick = $urandom_range(0, 99);
    k = lgpd_pkg::KEY_W'($urandom);
    g = lgpd_pkg::GEN_W'($urandom);
    rs = lgpd_pkg::ROW_W'($urandom);
    if (pick < 50) begin
      case ($urandom_range(0, 9))
        0, 1:    k = lgpd_pkg::KEY_UP;
        2, 3:    k = lgpd_pkg::KEY_DOWN;
        4, 5:    k = lgpd_pkg::KEY_LEFT;
        6, 7:    k = lgpd_pkg::KEY_RIGHT;
        8:       k = lgpd_pkg::KEY_PEN;
        default: k = lgpd_pkg::KEY_W'($urandom_range(0, 255));
      endcase
      issue_command(lgpd_pkg::CMD_KEY, k, g, rs);
    end else if (pick < 62) begin
      // long runs only on a dead area, which stops after one generation
      if (!area_is_dead()) g = lgpd_pkg::GEN_W'($urandom_range(0, 4));
      issue_command(lgpd_pkg::CMD_GEN, k, g, rs);
    end else if (pick < 93) begin
      if ($urandom_range(0, 4) != 0)
        rs = lgpd_pkg::ROW_W'($urandom_range(0, rows_in_use() - 1));
      issue_command(lgpd_pkg::CMD_READ, k, g, rs);
    end else begin
      issue_command(lgpd_pkg::CMD_CLEAR, k, g, rs);
    end
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Pen at the edges, ignored bytes, and a blinker driven through a long run
  task automatic test_pen_and_blinker();
    read_row(6'd0);
    key(lgpd_pkg::KEY_UP);
    key(lgpd_pkg::KEY_LEFT);
    key(8'h00);
    key(lgpd_pkg::KEY_DOWN);
    key(lgpd_pkg::KEY_PEN);
    key(lgpd_pkg::KEY_RIGHT);
    key(lgpd_pkg::KEY_RIGHT);
    key(lgpd_pkg::KEY_PEN);
    run_gens(16'hFFFF);
    read_row(6'd0);
    read_row(6'd1);
    run_gens(16'h0000);
    run_gens(16'h0001);
    read_row(6'd1);
    read_row(6'd63);
    key(8'hFF);
    issue_command(lgpd_pkg::CMD_CLEAR, 8'hFF, 16'hFFFF, 6'd63);
  endtask

  // Out-of-range register values clamp; the pen may end up outside the area
  task automatic test_dim_clamps();
    wait_idle();
    set_dims(7'd0, 7'd127);
    key(lgpd_pkg::KEY_RIGHT);
    key(lgpd_pkg::KEY_PEN);
    key(lgpd_pkg::KEY_DOWN);
    run_gens(16'd1);
    read_row(6'd1);
    wait_idle();
    set_dims(7'd127, 7'd0);
    key(lgpd_pkg::KEY_DOWN);
    read_row(6'd1);
    key(lgpd_pkg::KEY_UP);
    read_row(6'd0);
  endtask

  // Random phases over a range of grid sizes, with and without clearing between them
  task automatic test_random_phases();
    logic [lgpd_pkg::DIM_W-1:0] widths [9]  = '{7'd8, 7'd64, 7'd12, 7'd3, 7'd1, 7'd64, 7'd6,
                                                7'd0, 7'd0};
    logic [lgpd_pkg::DIM_W-1:0] heights [9] = '{7'd8, 7'd64, 7'd20, 7'd3, 7'd1, 7'd6, 7'd64,
                                                7'd0, 7'd0};
    logic [lgpd_pkg::DIM_W-1:0] w, h;
    for (int p = 0; p < 9; p++) begin
      wait_idle();
      w = (p >= 7) ? lgpd_pkg::DIM_W'($urandom_range(0, 127)) : widths[p];
      h = (p >= 7) ? lgpd_pkg::DIM_W'($urandom_range(0, 127)) : heights[p];
      set_dims(w, h);
      case ($urandom_range(0, 2))
        0:       begin gap_pct = 0;  stall_pct = 0;  end
        1:       begin gap_pct = 10; stall_pct = 10; end
        default: begin gap_pct = 30; stall_pct = 25; end
      endcase
      if ($urandom_range(0, 1)) issue_command(lgpd_pkg::CMD_CLEAR, '0, '0, '0);
      repeat (127) random_command();
    end
  endtask

  // Closing stretch with no idling on either side
  task automatic test_back_to_back_tail();
    wait_idle();
    set_dims(7'd16, 7'd16);
    gap_pct = 0;
    stall_pct = 0;
    repeat (100) random_command();
  endtask

  initial begin
    width_reg = lgpd_pkg::DIM_RESET;
    height_reg = lgpd_pkg::DIM_RESET;
    clear_cells();
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_pen_and_blinker();
    test_dim_clamps();
    test_random_phases();
    test_back_to_back_tail();

    wait_idle();
    repeat (20) @(posedge clk);
    $display("Sent %0d key, %0d step, %0d read and %0d clear commands over %0d size settings.",
             cmd_tally[lgpd_pkg::CMD_KEY], cmd_tally[lgpd_pkg::CMD_GEN],
             cmd_tally[lgpd_pkg::CMD_READ], cmd_tally[lgpd_pkg::CMD_CLEAR], dim_settings);
    $display("Checked %0d results; %0d mismatches.", reports_checked, error_count);
    if (error_count == 0) begin
      $display("tb_life_grid_with_pen_drawing: done, clean");
    end else begin
      $display("tb_life_grid_with_pen_drawing: done, errors");
    end
    $finish;
  end

  // Hard stop well past the slowest legal run (the long blinker run sweeps every generation)
  initial begin
    #100_000_000;
    $display("timeout with %0d results outstanding", pending_reports.size());
    $display("tb_life_grid_with_pen_drawing: done, errors");
    $finish;
  end

endmodule

// File: life_grid_with_pen_drawing.f
+incdir+hw/rtl
hw/rtl/lgpd_pkg.sv
hw/rtl/lgpd_ram.sv
hw/rtl/lgpd_ctrl.sv
hw/rtl/lgpd_dp.sv
hw/rtl/life_grid_with_pen_drawing.sv
sim/tb_life_grid_with_pen_drawing.sv
